@@ hdl/fit_strategy_chunk_allocator_macros.svh @@
// assertion macros shared by the chunk allocator rtl
`ifndef FIT_STRATEGY_CHUNK_ALLOCATOR_MACROS_SVH
`define FIT_STRATEGY_CHUNK_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSCA_ASSERT(lbl, prop, msg)
`define FSCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/fsca_pkg.sv @@
// ----------------------------------------------------------------------------
// fsca_pkg
// types, codes and sizes shared by the chunk allocator
// ----------------------------------------------------------------------------
package fsca_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [24:0] MEM_CAP       = 25'd16777216;
  localparam logic [1:0]  FIT_RESET     = 2'd0;
  localparam logic [24:0] MEM_RESET     = 25'd65536;
  localparam logic [7:0]  OVH_RESET     = 8'd16;

  typedef enum logic [1:0] {
    REG_FIT_STRATEGY    = 2'd0,
    REG_MEMORY_SIZE     = 2'd1,
    REG_HEADER_OVERHEAD = 2'd2
  } fsca_reg_e;

  typedef enum logic [1:0] {
    FIT_FIRST   = 2'd0,
    FIT_BEST    = 2'd1,
    FIT_WORST   = 2'd2,
    FIT_UNKNOWN = 2'd3
  } fsca_fit_e;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } fsca_cmd_e;

  typedef enum logic [2:0] {
    STAT_ALLOC_OK       = 3'd0,
    STAT_ALLOC_NO_FIT   = 3'd1,
    STAT_ALLOC_FULL     = 3'd2,
    STAT_RELEASE_OK     = 3'd3,
    STAT_RELEASE_NO_ID  = 3'd4
  } fsca_status_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_FINAL_HI,
    ST_FINAL_LO,
    ST_RESULT
  } fsca_state_e;

  typedef struct packed {
    logic        command;
    logic [15:0] owner_id;
    logic [23:0] request_bytes;
  } fsca_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [24:0] location;
  } fsca_out_t;

  typedef struct packed {
    logic [23:0] start;
    logic [24:0] size;
    logic [15:0] owner;
    logic        in_use;
  } fsca_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } fsca_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    fsca_entry_t      data;
  } fsca_wr_t;

endpackage

@@ hdl/fsca_table.sv @@
// ----------------------------------------------------------------------------
// fsca_table
// chunk table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fsca_table
  import fsca_pkg::*;
(
  input  logic        clk_i,
  input  fsca_rd_t    rd_i,
  output fsca_entry_t rd_data_o,
  input  fsca_wr_t    wr_i
);

  fsca_entry_t mem_q [TABLE_ENTRIES];
  fsca_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/fit_strategy_chunk_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_strategy_chunk_allocator
// chunk allocator with first, best and worst fit over an ordered chunk table
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i/in_ready_o) takes one request beat: allocate or
//   release. out channel (out_valid_o/out_ready_i) returns one beat per
//   request with status and location. config is a plain write port,
//   index 0 fit strategy, 1 memory size (rebuilds the table), 2 header size.
// timing:
//   one request at a time. a scan reads all live chunks through the table's
//   single read port; an allocate that splits then moves the chunks above
//   the hit up by one, a release that merges moves them down, one chunk a
//   cycle.
// reset:
//   registers go to first fit, 65536 bytes, 16 byte header; the init state
//   writes entry 0 as one free chunk and the block turns ready in the cycle after.
// stall:
//   the result sits in an output register; the next request is taken while
//   it waits, and its own result waits until the register is emptied.
// ----------------------------------------------------------------------------
`include "fit_strategy_chunk_allocator_macros.svh"

module fit_strategy_chunk_allocator
  import fsca_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  fsca_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fsca_out_t   out_data_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // configuration
  logic [1:0]       fit_q;
  logic [24:0]      mem_size_q;
  logic [7:0]       ovh_q;

  // sequencer state
  fsca_state_e      state_q, state_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             cmd_q, cmd_d;
  logic [15:0]      owner_q, owner_d;
  logic [24:0]      need_q, need_d;

  // scan pipeline: issue pointer and the entry coming back from the table
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             ev_v_q, ev_v_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;

  // chosen chunk (fit on allocate, match on release) and its neighbors
  logic             pick_v_q, pick_v_d;
  logic [IDX_W-1:0] pick_idx_q, pick_idx_d;
  fsca_entry_t      pick_q, pick_d;
  fsca_entry_t      prev_q, prev_d;
  logic             nxt_v_q, nxt_v_d;
  fsca_entry_t      nxt_q, nxt_d;

  // move engine for inserting or closing a gap in the table
  logic [CNT_W-1:0] sh_src_q, sh_src_d;
  logic [CNT_W-1:0] sh_last_q, sh_last_d;
  logic             sh_up_q, sh_up_d;
  logic             sh_iss_q, sh_iss_d;
  logic [1:0]       sh_r_q, sh_r_d;
  logic             pend_v_q, pend_v_d;
  logic [IDX_W-1:0] pend_dst_q, pend_dst_d;

  // result and output register
  fsca_out_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  fsca_out_t        out_q, out_d;

  fsca_rd_t         rd;
  fsca_wr_t         seq_wr, wr;
  fsca_entry_t      rd_data;

  // scan helpers
  logic             fits, take, match, iss_ok;
  logic             prev_free, next_free;
  logic [CNT_W-1:0] k_cnt, down_src;
  logic [24:0]      merged_size, cfg_mem_size;

  fsca_table u_table (
    .clk_i     (clk_i),
    .rd_i      (rd),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  assign cfg_mem_size = (cfg_wdata_i > MEM_CAP) ? MEM_CAP : cfg_wdata_i;

  // memory size writes rebuild entry 0 directly; after reset the init state does it
  always_comb begin
    wr = seq_wr;
    if (cfg_we_i && (cfg_idx_i == REG_MEMORY_SIZE)) begin
      wr.en   = 1'b1;
      wr.addr = '0;
      wr.data = '{start: '0, size: cfg_mem_size, owner: '0, in_use: 1'b0};
    end else if (state_q == ST_INIT) begin
      wr.en   = 1'b1;
      wr.addr = '0;
      wr.data = '{start: '0, size: mem_size_q, owner: '0, in_use: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q      <= FIT_RESET;
      mem_size_q <= MEM_RESET;
      ovh_q      <= OVH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIT_STRATEGY:    fit_q      <= cfg_wdata_i[1:0];
        REG_MEMORY_SIZE:     mem_size_q <= cfg_mem_size;
        REG_HEADER_OVERHEAD: ovh_q      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      total_q     <= CNT_W'(1);
      ev_v_q      <= 1'b0;
      sh_iss_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= (cfg_we_i && (cfg_idx_i == REG_MEMORY_SIZE)) ? CNT_W'(1) : total_d;
      ev_v_q      <= ev_v_d;
      sh_iss_q    <= sh_iss_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    owner_q    <= owner_d;
    need_q     <= need_d;
    iss_q      <= iss_d;
    ev_idx_q   <= ev_idx_d;
    pick_v_q   <= pick_v_d;
    pick_idx_q <= pick_idx_d;
    pick_q     <= pick_d;
    prev_q     <= prev_d;
    nxt_v_q    <= nxt_v_d;
    nxt_q      <= nxt_d;
    sh_src_q   <= sh_src_d;
    sh_last_q  <= sh_last_d;
    sh_up_q    <= sh_up_d;
    sh_r_q     <= sh_r_d;
    pend_dst_q <= pend_dst_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // scan compare: the single shared size compare and owner match
  assign fits  = !rd_data.in_use && (rd_data.size >= need_q) && (fit_q != FIT_UNKNOWN);
  assign take  = fits && (!pick_v_q ||
                          ((fit_q == FIT_BEST)  && (rd_data.size < pick_q.size)) ||
                          ((fit_q == FIT_WORST) && (rd_data.size > pick_q.size)));
  assign match = rd_data.in_use && (rd_data.owner == owner_q) && !pick_v_q;
  // a release keeps reading one entry past its match to see the next neighbor
  assign iss_ok = (iss_q < total_q) && !((cmd_q == CMD_RELEASE) && pick_v_q);

  // merge arithmetic for a release
  assign k_cnt       = CNT_W'(pick_idx_q);
  assign prev_free   = (pick_idx_q != '0) && !prev_q.in_use;
  assign next_free   = nxt_v_q && !nxt_q.in_use;
  assign merged_size = pick_q.size + (prev_free ? prev_q.size : 25'd0)
                                   + (next_free ? nxt_q.size : 25'd0);
  assign down_src    = k_cnt + CNT_W'(1) + CNT_W'(next_free);

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    cmd_d       = cmd_q;
    owner_d     = owner_q;
    need_d      = need_q;
    iss_d       = iss_q;
    ev_v_d      = 1'b0;
    ev_idx_d    = ev_idx_q;
    pick_v_d    = pick_v_q;
    pick_idx_d  = pick_idx_q;
    pick_d      = pick_q;
    prev_d      = prev_q;
    nxt_v_d     = nxt_v_q;
    nxt_d       = nxt_q;
    sh_src_d    = sh_src_q;
    sh_last_d   = sh_last_q;
    sh_up_d     = sh_up_q;
    sh_iss_d    = sh_iss_q;
    sh_r_d      = sh_r_q;
    pend_v_d    = 1'b0;
    pend_dst_d  = pend_dst_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd          = '0;
    seq_wr      = '0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        state_d = ST_IDLE;
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = in_data_i.command;
          owner_d  = in_data_i.owner_id;
          need_d   = {1'b0, in_data_i.request_bytes} + {17'd0, ovh_q};
          iss_d    = '0;
          pick_v_d = 1'b0;
          nxt_v_d  = 1'b0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (iss_ok) begin
          rd.en    = 1'b1;
          rd.addr  = iss_q[IDX_W-1:0];
          iss_d    = iss_q + CNT_W'(1);
          ev_v_d   = 1'b1;
          ev_idx_d = iss_q[IDX_W-1:0];
        end
        if (ev_v_q) begin
          if (cmd_q == CMD_ALLOC) begin
            if (take) begin
              pick_v_d   = 1'b1;
              pick_idx_d = ev_idx_q;
              pick_d     = rd_data;
            end
          end else if (pick_v_q) begin
            nxt_v_d = 1'b1;
            nxt_d   = rd_data;
          end else if (match) begin
            pick_v_d   = 1'b1;
            pick_idx_d = ev_idx_q;
            pick_d     = rd_data;
          end else begin
            prev_d = rd_data;
          end
        end
        if (!ev_v_q && !iss_ok) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_RESULT;
        res_d   = '{status: STAT_ALLOC_NO_FIT, location: '0};
        if (cmd_q == CMD_ALLOC) begin
          if (!pick_v_q) begin
            res_d = '{status: STAT_ALLOC_NO_FIT, location: '0};
          end else if ((pick_q.size > need_q) && (total_q == FULL_CNT)) begin
            res_d = '{status: STAT_ALLOC_FULL, location: '0};
          end else begin
            res_d = '{status: STAT_ALLOC_OK,
                      location: {1'b0, pick_q.start} + {17'd0, ovh_q}};
            if (pick_q.size > need_q) begin
              total_d = total_q + CNT_W'(1);
              if ((k_cnt + CNT_W'(1)) < total_q) begin
                sh_src_d  = total_q - CNT_W'(1);
                sh_last_d = k_cnt + CNT_W'(1);
                sh_up_d   = 1'b1;
                sh_iss_d  = 1'b1;
                state_d   = ST_SHIFT;
              end else begin
                state_d = ST_FINAL_HI;
              end
            end else begin
              state_d = ST_FINAL_LO;
            end
          end
        end else if (!pick_v_q) begin
          res_d = '{status: STAT_RELEASE_NO_ID, location: '0};
        end else begin
          res_d = '{status: STAT_RELEASE_OK,
                    location: {1'b0, pick_q.start} + {17'd0, ovh_q}};
          // the freed chunk absorbs free neighbors on either side
          seq_wr.en   = 1'b1;
          seq_wr.addr = prev_free ? (pick_idx_q - IDX_W'(1)) : pick_idx_q;
          seq_wr.data = '{start:  prev_free ? prev_q.start : pick_q.start,
                          size:   merged_size,
                          owner:  prev_free ? prev_q.owner : pick_q.owner,
                          in_use: 1'b0};
          sh_r_d  = {1'b0, prev_free} + {1'b0, next_free};
          total_d = total_q - CNT_W'(prev_free) - CNT_W'(next_free);
          if ((prev_free || next_free) && (down_src < total_q)) begin
            sh_src_d  = down_src;
            sh_last_d = total_q - CNT_W'(1);
            sh_up_d   = 1'b0;
            sh_iss_d  = 1'b1;
            state_d   = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        if (sh_iss_q) begin
          rd.en    = 1'b1;
          rd.addr  = sh_src_q[IDX_W-1:0];
          pend_v_d = 1'b1;
          pend_dst_d = sh_up_q ? (sh_src_q[IDX_W-1:0] + IDX_W'(1))
                               : (sh_src_q[IDX_W-1:0] - IDX_W'(sh_r_q));
          if (sh_src_q == sh_last_q) begin
            sh_iss_d = 1'b0;
          end else begin
            sh_src_d = sh_up_q ? (sh_src_q - CNT_W'(1)) : (sh_src_q + CNT_W'(1));
          end
        end
        if (pend_v_q) begin
          seq_wr.en   = 1'b1;
          seq_wr.addr = pend_dst_q;
          seq_wr.data = rd_data;
        end
        if (!sh_iss_q && !pend_v_q) begin
          state_d = sh_up_q ? ST_FINAL_HI : ST_RESULT;
        end
      end

      ST_FINAL_HI: begin
        // remainder of the split chunk, free, right after the hit
        seq_wr.en   = 1'b1;
        seq_wr.addr = pick_idx_q + IDX_W'(1);
        seq_wr.data = '{start:  pick_q.start + need_q[23:0],
                        size:   pick_q.size - need_q,
                        owner:  '0,
                        in_use: 1'b0};
        state_d = ST_FINAL_LO;
      end

      ST_FINAL_LO: begin
        seq_wr.en   = 1'b1;
        seq_wr.addr = pick_idx_q;
        seq_wr.data = '{start: pick_q.start, size: need_q, owner: owner_q, in_use: 1'b1};
        state_d = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic out_load;
  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  `FSCA_ASSERT(a_total_range, (total_q != '0) && (total_q <= FULL_CNT), "chunk count out of range")
  `FSCA_ASSERT(a_full_status, (out_load && (res_q.status == STAT_ALLOC_FULL)) |-> (total_q == FULL_CNT), "table full reported with room left")
  `FSCA_ASSERT(a_fail_zero_loc, (out_load && (res_q.status != STAT_ALLOC_OK) && (res_q.status != STAT_RELEASE_OK)) |-> (res_q.location == '0), "failed request carries a location")
  `FSCA_ASSERT(a_move_in_table, (state_q == ST_SHIFT && seq_wr.en) |-> (CNT_W'(seq_wr.addr) < total_q), "chunk move writes past the table end")
  `FSCA_ASSERT_NEXT(a_busy_blocks, (state_q == ST_SCAN), !in_ready_o, "request taken during a scan")

endmodule
